/* hw/rtl/thodo_pkg.sv */
// ----------------------------------------------------------------------------
// Two-wheel heading odometry package
// Shared widths, register indexes, opcodes and the control bundle of the
// bit-serial multiplier.
// ----------------------------------------------------------------------------
package thodo_pkg;

    localparam int CNT_W      = 32;
    localparam int PM_W       = 24;
    localparam int POS_W      = 48;
    localparam int TRIG_W     = 16;
    localparam int TAB_W      = 15;
    localparam int HEAD_W     = 16;
    localparam int MCAND_W    = CNT_W + PM_W;
    localparam int MPLIER_W   = PM_W + 1;
    localparam int PROD_W     = MCAND_W + MPLIER_W;
    localparam int QPROD_W    = MCAND_W + TRIG_W;
    localparam int FRAC_W     = TRIG_W - 1;
    localparam int MQ_W       = QPROD_W - FRAC_W;
    localparam int DSUM_W     = MQ_W + 1;
    localparam int ASUM_W     = DSUM_W + 1;

    localparam int IN_DATA_W  = 2 * CNT_W + HEAD_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * POS_W;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = POS_W;

    localparam int DEF_ANGLE_BITS = 16;
    localparam int DEF_SINE_DEPTH = 1024;

    localparam logic [PM_W-1:0] PM_RESET = 24'd7979800;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSVERSE_PM = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_PM     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 8'd3;

    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        logic step;
        logic last;
    } t_mul_ctrl;

endpackage

/* hw/rtl/thodo_serial_mul.sv */
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Shift-and-add over the multiplier bits, one bit per step; the top bit of
// the multiplier carries negative weight.
// ----------------------------------------------------------------------------
module thodo_serial_mul #(
    parameter int MW = thodo_pkg::MCAND_W,
    parameter int NW = thodo_pkg::MPLIER_W
) (
    input  logic                  i_clk,
    input  thodo_pkg::t_mul_ctrl  i_ctrl,
    input  logic [MW-1:0]         i_multiplicand,
    input  logic [NW-1:0]         i_multiplier,
    output logic [MW+NW-1:0]      o_product
);
    import thodo_pkg::*;

    logic [MW-1:0]   r_mcand;
    logic [MW:0]     r_hi;
    logic [NW-1:0]   r_q;
    logic [MW+1:0]   w_ext;
    logic [MW+1:0]   w_addend;
    logic [MW+1:0]   w_sum;
    logic [MW+NW:0]  w_full;

    always_comb begin
        w_ext = {{2{r_mcand[MW-1]}}, r_mcand};
        if (!r_q[0]) begin
            w_addend = '0;
        end else if (i_ctrl.last) begin
            w_addend = -w_ext;
        end else begin
            w_addend = w_ext;
        end
        w_sum = {r_hi[MW], r_hi} + w_addend;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_mcand <= i_multiplicand;
            r_hi    <= '0;
            r_q     <= i_multiplier;
        end else if (i_ctrl.step) begin
            r_hi <= w_sum[MW+1:1];
            r_q  <= {w_sum[0], r_q[NW-1:1]};
        end
    end

    assign w_full    = {r_hi, r_q};
    assign o_product = w_full[MW+NW-1:0];

endmodule

/* hw/rtl/thodo_sine_rom.sv */
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Q0.15 sine points over a quarter turn, built at elaboration from an
// integer Taylor series, with a registered read.
// ----------------------------------------------------------------------------
module thodo_sine_rom #(
    parameter int DEPTH = thodo_pkg::DEF_SINE_DEPTH,
    parameter int IW    = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic [IW-1:0]                i_addr,
    output logic [thodo_pkg::TAB_W-1:0]  o_data
);
    import thodo_pkg::*;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int ROWS = 2 ** IW;

    function automatic logic [TAB_W-1:0] f_sine_point(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] e;
        x    = (HALF_PI_Q30 * 64'(i)) / DEPTH;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 12; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = (sum + 64'sd16384) >>> 15;
        if (e > 64'sd32767) begin
            e = 64'sd32767;
        end
        return e[TAB_W-1:0];
    endfunction

    logic [TAB_W-1:0] w_tab [ROWS];

    for (genvar g = 0; g < ROWS; g++) begin : g_point
        localparam logic [TAB_W-1:0] POINT = (g <= DEPTH) ? f_sine_point(g) : '0;
        assign w_tab[g] = POINT;
    end

    always_ff @(posedge i_clk) begin
        o_data <= w_tab[i_addr];
    end

endmodule

/* hw/rtl/two_wheel_heading_odometry_unit.sv */
// ----------------------------------------------------------------------------
// Two-wheel heading odometry unit
// Dead reckoning from a transverse and a radial tracking wheel and a heading.
// Wheel deltas are scaled, rotated by the heading and added to saturating
// X/Y positions in picometres.
//
//   Channel  Dir  Handshake                        Payload
//   s_axis   in   i_s_axis_tvalid/o_s_axis_tready  counts, heading, opcode
//   m_axis   out  o_m_axis_tvalid/i_m_axis_tready  positions, flags
//   cfg      in   i_cfg_valid/o_cfg_ready          register index, data
//
// An update item holds the unit from transfer until it is idle again: a
// scaling and a rotating pass through the bit-serial multipliers, one step
// per multiplier bit, then rounding, summing, accumulation and output. An
// init item goes straight to output. The result register lets a new item
// be taken while the last result waits; a stalled output holds the unit in
// its output state. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module two_wheel_heading_odometry_unit #(
    parameter int ANGLE_BITS       = thodo_pkg::DEF_ANGLE_BITS,
    parameter int SINE_TABLE_DEPTH = thodo_pkg::DEF_SINE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // transverse_count[31:0], radial_count[63:32], heading_angle[79:64]
    input  logic [thodo_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // opcode[0]
    input  logic [thodo_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // pos_x[47:0], pos_y[95:48]
    output logic [thodo_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // is_initialized[0], clipped[1]
    output logic [thodo_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [thodo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [thodo_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import thodo_pkg::*;

    localparam int AW  = ANGLE_BITS;
    localparam int QW  = AW - 2;
    localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW  = QW + IW;
    localparam int SCW = $clog2(MPLIER_W);
    localparam logic [SCW-1:0] CNT_LAST  = SCW'(MPLIER_W - 1);
    localparam logic [SCW-1:0] CNT_SIN_A = SCW'(1);
    localparam logic [SCW-1:0] CNT_SIN_B = SCW'(2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MULA  = 3'd1;
    localparam logic [2:0] S_LOADB = 3'd2;
    localparam logic [2:0] S_MULB  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]        r_state;
    logic [SCW-1:0]    r_cnt;
    logic [PM_W-1:0]   r_pm_t;
    logic [PM_W-1:0]   r_pm_r;
    logic [POS_W-1:0]  r_start_x;
    logic [POS_W-1:0]  r_start_y;
    logic [CNT_W-1:0]  r_prev_t;
    logic [CNT_W-1:0]  r_prev_r;
    logic [POS_W-1:0]  r_acc_x;
    logic [POS_W-1:0]  r_acc_y;
    logic              r_init_done;
    logic              r_clip;
    logic [IW-1:0]     r_idx;
    logic [1:0]        r_quad;
    logic [TAB_W-1:0]  r_sin_a;
    logic [TAB_W-1:0]  r_sin_b;
    logic [MQ_W-1:0]   r_mq [4];
    logic [DSUM_W-1:0] r_dx;
    logic [DSUM_W-1:0] r_dy;
    logic              r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_USER_W-1:0] r_m_user;

    logic              w_s_fire;
    logic              w_out_free;
    logic [CNT_W-1:0]  w_tc;
    logic [CNT_W-1:0]  w_rc;
    logic [CNT_W-1:0]  w_dt;
    logic [CNT_W-1:0]  w_dr;
    logic [AW+HEAD_W-1:0] w_ang_ext;
    logic [AW-1:0]     w_ang;
    logic [PW-1:0]     w_pos_scaled;
    logic [IW-1:0]     w_rom_addr;
    logic [TAB_W-1:0]  w_rom_q;
    logic [TRIG_W-1:0] w_a;
    logic [TRIG_W-1:0] w_b;
    logic [TRIG_W-1:0] w_sn;
    logic [TRIG_W-1:0] w_cs;
    t_mul_ctrl         w_ctrl_ab;
    t_mul_ctrl         w_ctrl_cd;
    logic [MCAND_W-1:0]  w_mcand [4];
    logic [MPLIER_W-1:0] w_mplier [4];
    logic [PROD_W-1:0]   w_prod [4];
    logic [QPROD_W-1:0]  w_rnd [4];
    logic [ASUM_W-1:0] w_sum_x;
    logic [ASUM_W-1:0] w_sum_y;
    logic              w_hi_x;
    logic              w_lo_x;
    logic              w_hi_y;
    logic              w_lo_y;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;

    assign w_tc = i_s_axis_tdata[CNT_W-1:0];
    assign w_rc = i_s_axis_tdata[2*CNT_W-1:CNT_W];
    assign w_dt = w_tc - r_prev_t;
    assign w_dr = w_rc - r_prev_r;

    assign w_ang_ext    = (AW+HEAD_W)'(i_s_axis_tdata[IN_DATA_W-1:2*CNT_W]);
    assign w_ang        = w_ang_ext[AW-1:0];
    assign w_pos_scaled = PW'(w_ang[QW-1:0]) * PW'(SINE_TABLE_DEPTH);

    assign w_rom_addr = (r_cnt == '0) ? r_idx : IW'(SINE_TABLE_DEPTH) - r_idx;

    thodo_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH),
        .IW    (IW)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_q)
    );

    always_comb begin
        w_a = {1'b0, r_sin_a};
        w_b = {1'b0, r_sin_b};
        case (r_quad)
            2'd0: begin
                w_sn = w_a;
                w_cs = w_b;
            end
            2'd1: begin
                w_sn = w_b;
                w_cs = -w_a;
            end
            2'd2: begin
                w_sn = -w_a;
                w_cs = -w_b;
            end
            default: begin
                w_sn = -w_b;
                w_cs = w_a;
            end
        endcase
    end

    // Units 0 and 1 scale the radial and transverse deltas, then all four
    // form r*sin, t*cos, r*cos and t*sin.
    always_comb begin
        w_ctrl_ab.start = (w_s_fire && (i_s_axis_tuser[0] == OP_UPDATE))
                        || (r_state == S_LOADB);
        w_ctrl_ab.step  = (r_state == S_MULA) || (r_state == S_MULB);
        w_ctrl_ab.last  = (r_cnt == CNT_LAST);
        w_ctrl_cd.start = (r_state == S_LOADB);
        w_ctrl_cd.step  = (r_state == S_MULB);
        w_ctrl_cd.last  = (r_cnt == CNT_LAST);

        if (r_state == S_IDLE) begin
            w_mcand[0]  = {{(MCAND_W-CNT_W){w_dr[CNT_W-1]}}, w_dr};
            w_mcand[1]  = {{(MCAND_W-CNT_W){w_dt[CNT_W-1]}}, w_dt};
            w_mplier[0] = {1'b0, r_pm_r};
            w_mplier[1] = {1'b0, r_pm_t};
        end else begin
            w_mcand[0]  = w_prod[0][MCAND_W-1:0];
            w_mcand[1]  = w_prod[1][MCAND_W-1:0];
            w_mplier[0] = {{(MPLIER_W-TRIG_W){w_sn[TRIG_W-1]}}, w_sn};
            w_mplier[1] = {{(MPLIER_W-TRIG_W){w_cs[TRIG_W-1]}}, w_cs};
        end
        w_mcand[2]  = w_prod[0][MCAND_W-1:0];
        w_mcand[3]  = w_prod[1][MCAND_W-1:0];
        w_mplier[2] = {{(MPLIER_W-TRIG_W){w_cs[TRIG_W-1]}}, w_cs};
        w_mplier[3] = {{(MPLIER_W-TRIG_W){w_sn[TRIG_W-1]}}, w_sn};
    end

    for (genvar u = 0; u < 4; u++) begin : g_mul
        thodo_serial_mul #(
            .MW (MCAND_W),
            .NW (MPLIER_W)
        ) u_mul (
            .i_clk          (i_clk),
            .i_ctrl         ((u < 2) ? w_ctrl_ab : w_ctrl_cd),
            .i_multiplicand (w_mcand[u]),
            .i_multiplier   (w_mplier[u]),
            .o_product      (w_prod[u])
        );
        assign w_rnd[u] = w_prod[u][QPROD_W-1:0] + QPROD_W'(16384);
    end

    always_comb begin
        w_sum_x = {{(ASUM_W-POS_W){r_acc_x[POS_W-1]}}, r_acc_x}
                + {r_dx[DSUM_W-1], r_dx};
        w_sum_y = {{(ASUM_W-POS_W){r_acc_y[POS_W-1]}}, r_acc_y}
                + {r_dy[DSUM_W-1], r_dy};
        w_hi_x  = !w_sum_x[ASUM_W-1] && (|w_sum_x[ASUM_W-2:POS_W-1]);
        w_lo_x  = w_sum_x[ASUM_W-1] && !(&w_sum_x[ASUM_W-2:POS_W-1]);
        w_hi_y  = !w_sum_y[ASUM_W-1] && (|w_sum_y[ASUM_W-2:POS_W-1]);
        w_lo_y  = w_sum_y[ASUM_W-1] && !(&w_sum_y[ASUM_W-2:POS_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pm_t      <= PM_RESET;
            r_pm_r      <= PM_RESET;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_prev_t    <= '0;
            r_prev_r    <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_init_done <= 1'b0;
            r_clip      <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TRANSVERSE_PM: r_pm_t    <= i_cfg_data[PM_W-1:0];
                    CFG_RADIAL_PM:     r_pm_r    <= i_cfg_data[PM_W-1:0];
                    CFG_START_X:       r_start_x <= i_cfg_data[POS_W-1:0];
                    CFG_START_Y:       r_start_y <= i_cfg_data[POS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if ((r_state == S_OUT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_s_fire) begin
                        r_prev_t <= w_tc;
                        r_prev_r <= w_rc;
                        r_clip   <= 1'b0;
                        r_cnt    <= '0;
                        if (i_s_axis_tuser[0] == OP_INIT) begin
                            r_acc_x     <= r_start_x;
                            r_acc_y     <= r_start_y;
                            r_init_done <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_state <= S_MULA;
                        end
                    end
                end
                S_MULA: begin
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_LOADB;
                    end else begin
                        r_cnt <= r_cnt + SCW'(1);
                    end
                end
                S_LOADB: begin
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + SCW'(1);
                    end
                end
                S_ROUND: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_hi_x) begin
                        r_acc_x <= POS_MAX;
                    end else if (w_lo_x) begin
                        r_acc_x <= POS_MIN;
                    end else begin
                        r_acc_x <= w_sum_x[POS_W-1:0];
                    end
                    if (w_hi_y) begin
                        r_acc_y <= POS_MAX;
                    end else if (w_lo_y) begin
                        r_acc_y <= POS_MIN;
                    end else begin
                        r_acc_y <= w_sum_y[POS_W-1:0];
                    end
                    r_clip  <= w_hi_x || w_lo_x || w_hi_y || w_lo_y;
                    r_state <= S_OUT;
                end
                default: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_idx  <= w_pos_scaled[PW-1:QW];
            r_quad <= w_ang[AW-1:AW-2];
        end
        if ((r_state == S_MULA) && (r_cnt == CNT_SIN_A)) begin
            r_sin_a <= w_rom_q;
        end
        if ((r_state == S_MULA) && (r_cnt == CNT_SIN_B)) begin
            r_sin_b <= w_rom_q;
        end
        if (r_state == S_ROUND) begin
            for (int k = 0; k < 4; k++) begin
                r_mq[k] <= w_rnd[k][QPROD_W-1:FRAC_W];
            end
        end
        if (r_state == S_SUM) begin
            r_dx <= {r_mq[0][MQ_W-1], r_mq[0]} + {r_mq[1][MQ_W-1], r_mq[1]};
            r_dy <= {r_mq[2][MQ_W-1], r_mq[2]} - {r_mq[3][MQ_W-1], r_mq[3]};
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_m_data <= {r_acc_y, r_acc_x};
            r_m_user <= {r_clip, r_init_done};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    a_update_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && (i_s_axis_tuser[0] == OP_UPDATE))
        |=> ((r_state == S_MULA) && (r_cnt == '0)))
        else $error("update transfer did not start the scaling pass");

    a_init_loads_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && (i_s_axis_tuser[0] == OP_INIT))
        |=> (r_init_done && (r_acc_x == $past(r_start_x))
             && (r_acc_y == $past(r_start_y))))
        else $error("init transfer did not load the start position");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output state");

    a_clip_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1])
        |-> ((o_m_axis_tdata[POS_W-1:0] == POS_MAX)
             || (o_m_axis_tdata[POS_W-1:0] == POS_MIN)
             || (o_m_axis_tdata[2*POS_W-1:POS_W] == POS_MAX)
             || (o_m_axis_tdata[2*POS_W-1:POS_W] == POS_MIN)))
        else $error("clipped flag without a saturated position");

endmodule
